### hw/rtl/bsc_pkg.sv
// Shared constants, register map and divider interface types of the battery status classifier.
package bsc_pkg;

	// Serial divider geometry: 16-bit dividend, 7-bit divisor, one quotient bit a cycle.
	localparam int DIV_W = 16;
	localparam int DEN_W = 7;
	localparam int CNT_W = $clog2(DIV_W);

	// Gauge constants.
	localparam logic [16:0] TEMP_ZERO_DK = 17'd2731;
	localparam logic [6:0]  PCT_FULL     = 7'd100;
	localparam logic [6:0]  PCT_FALLBACK = 7'd50;
	localparam logic [3:0]  SHIFT_MAX    = 4'd10;

	// Division by ten as a reciprocal multiply and shift, exact for any 16-bit magnitude.
	localparam logic [15:0] TEN_RECIP       = 16'hCCCD;
	localparam int          TEN_RECIP_SHIFT = 19;

	// Status word flag positions.
	localparam int FLAG_EMPTY    = 4;
	localparam int FLAG_FULL     = 5;
	localparam int FLAG_DISCHG   = 6;
	localparam int FLAG_OVERTEMP = 12;
	localparam int FLAG_OVERCHG  = 15;

	// Register indexes (byte address is four times the index).
	localparam logic [1:0] REG_SOC_SHIFT    = 2'd0;
	localparam logic [1:0] REG_ALARM_ENABLE = 2'd1;
	localparam logic [1:0] REG_ALARM_TEMP   = 2'd2;

	// Charge status codes.
	localparam logic [2:0] STAT_UNKNOWN      = 3'd0;
	localparam logic [2:0] STAT_CHARGING     = 3'd1;
	localparam logic [2:0] STAT_DISCHARGING  = 3'd2;
	localparam logic [2:0] STAT_NOT_CHARGING = 3'd3;
	localparam logic [2:0] STAT_FULL         = 3'd4;

	// Health codes.
	localparam logic [2:0] HEALTH_UNKNOWN  = 3'd0;
	localparam logic [2:0] HEALTH_GOOD     = 3'd1;
	localparam logic [2:0] HEALTH_OVERHEAT = 3'd2;
	localparam logic [2:0] HEALTH_DEAD     = 3'd3;
	localparam logic [2:0] HEALTH_FAILURE  = 3'd4;

	// Capacity level codes.
	localparam logic [1:0] LEVEL_UNKNOWN  = 2'd0;
	localparam logic [1:0] LEVEL_CRITICAL = 2'd1;
	localparam logic [1:0] LEVEL_NORMAL   = 2'd2;
	localparam logic [1:0] LEVEL_FULL     = 2'd3;

	// Charger event codes.
	localparam logic [1:0] EV_DISCHARGING = 2'd0;
	localparam logic [1:0] EV_CHARGING    = 2'd1;
	localparam logic [1:0] EV_DONE        = 2'd2;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

### hw/rtl/bsc_div.sv
// Restoring serial divider, one quotient bit per clock, shared by the rescaling divisions.
module bsc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bsc_pkg::div_req_t req,
	output bsc_pkg::div_rsp_t rsp
);

	logic                        busy_q;
	logic                        done_q;
	logic [bsc_pkg::CNT_W-1:0]   cnt_q;
	logic [bsc_pkg::DEN_W-1:0]   rem_q;
	logic [bsc_pkg::DEN_W-1:0]   den_q;
	logic [bsc_pkg::DIV_W-1:0]   quo_q;

	logic [bsc_pkg::DEN_W:0]     trial;
	logic [bsc_pkg::DEN_W:0]     diff;
	logic                        fits;
	logic [bsc_pkg::DEN_W-1:0]   rem_nx;

	// The partial remainder stays below the divisor, so the trial value never overflows.
	assign trial  = {rem_q, quo_q[bsc_pkg::DIV_W-1]};
	assign diff   = trial - {1'b0, den_q};
	assign fits   = (trial >= {1'b0, den_q});
	assign rem_nx = fits ? diff[bsc_pkg::DEN_W-1:0] : trial[bsc_pkg::DEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start &&
				(cnt_q == bsc_pkg::CNT_W'(bsc_pkg::DIV_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == bsc_pkg::CNT_W'(bsc_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[bsc_pkg::DIV_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

### hw/rtl/battery_status_soc_classifier_top.sv
// Top level of the battery status and state-of-charge classifier.
//
//   Channel   Direction  Handshake                 Payload
//   -------   ---------  ------------------------  ------------------------------------------
//   in        sink       in_valid / in_ready       func, raw_charge, charge_ok, status_bits,
//                                                  status_ok, raw_temp, temp_ok, charger_event
//   out       source     out_valid / out_ready     poll_ok, status_code, health_code,
//                                                  level_code, charge_percent, temp_c,
//                                                  status_changed
//   cfg       APB slave  psel / penable / pready   paddr, pwrite, pwdata, prdata
//
// A charger event, or a poll whose status read failed, goes from acceptance straight to the
// final state and then to the result register. A full poll passes through the temperature
// step (a reciprocal multiply, taken only when the temperature read succeeded), the decode,
// up to two rescaling divisions on the shared serial divider, and the final state before the result register.
// in_ready is high only while the sequencer is idle; a stalled output holds it in its final
// state. Reset (arst_n low, asynchronous) returns all gauge state and registers to defaults.
module battery_status_soc_classifier_top (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic [6:0]         raw_charge,
	input  logic               charge_ok,
	input  logic [15:0]        status_bits,
	input  logic               status_ok,
	input  logic [15:0]        raw_temp,
	input  logic               temp_ok,
	input  logic [1:0]         charger_event,

	output logic               out_valid,
	input  logic               out_ready,
	output logic               poll_ok,
	output logic [2:0]         status_code,
	output logic [2:0]         health_code,
	output logic [1:0]         level_code,
	output logic [6:0]         charge_percent,
	output logic signed [7:0]  temp_c,
	output logic               status_changed,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TEMP,
		S_DECODE,
		S_SDIV,
		S_FDIV,
		S_FIN
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [3:0]        soc_shift_q;
	logic              alarm_en_q;
	logic signed [7:0] alarm_temp_q;

	// Gauge state that persists between words.
	logic [6:0]        charge_level_q;
	logic [6:0]        full_scale_q;
	logic [2:0]        report_status_q;
	logic [2:0]        health_q;
	logic [1:0]        level_q;
	logic signed [7:0] last_temp_q;
	logic [1:0]        charger_mode_q;

	// The word being worked on.
	logic [6:0]        pct_q;
	logic [15:0]       st_q;
	logic              neg_q;
	logic [15:0]       tmag_q;
	logic              ok_q;
	logic              changed_q;

	// Result register.
	logic              out_valid_q;
	logic              poll_ok_q;
	logic [2:0]        status_code_q;
	logic [2:0]        health_code_q;
	logic [1:0]        level_code_q;
	logic [6:0]        charge_percent_q;
	logic signed [7:0] temp_c_q;
	logic              status_changed_q;

	bsc_pkg::div_req_t div_req_q;
	bsc_pkg::div_rsp_t div_rsp;

	logic              in_fire;
	logic              cfg_write;
	logic [6:0]        pct_in;
	logic [16:0]       temp_diff;
	logic [15:0]       temp_mag;
	logic [31:0]       temp_prod;
	logic [12:0]       temp_quo;
	logic              temp_over;
	logic              overheat;
	logic              norm_path;
	logic              div_go;
	logic [13:0]       round_num;
	logic [13:0]       shift_off;
	logic [6:0]        shift_den;
	logic [6:0]        div_small;
	logic              div_over;
	logic [6:0]        div_clamped;
	logic              slot_free;
	logic signed [7:0] temp_pos;

	bsc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	// Status that a normal poll reports once the rescaled charge is known.
	function automatic logic [2:0] norm_status(input logic [6:0] c, input logic [1:0] mode,
		input logic dis);
		logic [2:0] s;
		if (c >= bsc_pkg::PCT_FULL) begin
			s = bsc_pkg::STAT_FULL;
		end else if (mode != bsc_pkg::EV_CHARGING) begin
			s = bsc_pkg::STAT_NOT_CHARGING;
		end else if (dis) begin
			s = bsc_pkg::STAT_DISCHARGING;
		end else begin
			s = bsc_pkg::STAT_CHARGING;
		end
		return s;
	endfunction

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign slot_free = !out_valid_q || out_ready;

	// Charge input: saturate above full, fall back to half when the read failed.
	assign pct_in = !charge_ok ? bsc_pkg::PCT_FALLBACK :
		((raw_charge > bsc_pkg::PCT_FULL) ? bsc_pkg::PCT_FULL : raw_charge);

	// Temperature in tenths of a degree above zero Celsius; its magnitude is divided by ten
	// and the sign put back, which rounds toward zero.
	assign temp_diff = {1'b0, raw_temp} - bsc_pkg::TEMP_ZERO_DK;
	assign temp_mag  = temp_diff[16] ? 16'(-temp_diff) : temp_diff[15:0];
	assign temp_prod = {16'd0, tmag_q} * {16'd0, bsc_pkg::TEN_RECIP};
	assign temp_quo  = temp_prod[31:bsc_pkg::TEN_RECIP_SHIFT];
	assign temp_over = (temp_quo > 13'(bsc_pkg::PCT_FULL));
	assign temp_pos  = {1'b0, temp_quo[6:0]};

	assign overheat = st_q[bsc_pkg::FLAG_OVERTEMP] || (alarm_en_q && (last_temp_q >= alarm_temp_q));

	// The plain decode path, with no flag taking priority over the rescaled charge.
	assign norm_path = !st_q[bsc_pkg::FLAG_FULL] && !st_q[bsc_pkg::FLAG_EMPTY] && !overheat &&
		!st_q[bsc_pkg::FLAG_OVERCHG];

	// Offset rescaling: (pct*100 + 50 - shift*100) / (100 - shift).
	assign round_num = 14'(pct_q) * 14'd100 + 14'd50;
	assign shift_off = 14'(soc_shift_q) * 14'd100;
	assign shift_den = bsc_pkg::PCT_FULL - 7'(soc_shift_q);

	// A division starts after a plain-path decode when the offset leaves some charge and the
	// learned full scale does not clip it, and again after the first one when a full scale is known.
	assign div_go = ((state_q == S_DECODE) && norm_path &&
		!((full_scale_q != '0) && (pct_q > full_scale_q)) && (round_num > shift_off)) ||
		((state_q == S_SDIV) && div_rsp.done && (full_scale_q != '0));

	assign div_over    = (div_rsp.quotient > 16'(bsc_pkg::PCT_FULL));
	assign div_small   = div_rsp.quotient[6:0];
	assign div_clamped = div_over ? bsc_pkg::PCT_FULL : div_small;

	// Register file and read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soc_shift_q  <= '0;
			alarm_en_q   <= 1'b0;
			alarm_temp_q <= 8'sd45;
		end else if (cfg_write) begin
			case (paddr[3:2])
				bsc_pkg::REG_SOC_SHIFT: begin
					soc_shift_q <= (pwdata[3:0] > bsc_pkg::SHIFT_MAX) ? bsc_pkg::SHIFT_MAX :
						pwdata[3:0];
				end
				bsc_pkg::REG_ALARM_ENABLE: begin
					alarm_en_q <= pwdata[0];
				end
				bsc_pkg::REG_ALARM_TEMP: begin
					alarm_temp_q <= signed'(pwdata[7:0]);
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			bsc_pkg::REG_SOC_SHIFT:    prdata = {28'd0, soc_shift_q};
			bsc_pkg::REG_ALARM_ENABLE: prdata = {31'd0, alarm_en_q};
			bsc_pkg::REG_ALARM_TEMP:   prdata = 32'(alarm_temp_q);
			default:                   prdata = '0;
		endcase
	end

	// Sequencer, gauge state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			charge_level_q   <= '0;
			full_scale_q     <= '0;
			report_status_q  <= bsc_pkg::STAT_DISCHARGING;
			health_q         <= bsc_pkg::HEALTH_UNKNOWN;
			level_q          <= bsc_pkg::LEVEL_UNKNOWN;
			last_temp_q      <= '0;
			charger_mode_q   <= bsc_pkg::EV_DISCHARGING;
			out_valid_q      <= 1'b0;
			div_req_q        <= '0;
			pct_q            <= '0;
			st_q             <= '0;
			neg_q            <= 1'b0;
			tmag_q           <= '0;
			ok_q             <= 1'b0;
			changed_q        <= 1'b0;
			poll_ok_q        <= 1'b0;
			status_code_q    <= '0;
			health_code_q    <= '0;
			level_code_q     <= '0;
			charge_percent_q <= '0;
			temp_c_q         <= '0;
			status_changed_q <= 1'b0;
		end else begin
			div_req_q.start <= div_go;
			// The result slot fills from the final state and empties on a taken word.
			out_valid_q <= ((state_q == S_FIN) && slot_free) || (out_valid_q && !out_ready);

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						pct_q  <= pct_in;
						st_q   <= status_bits;
						neg_q  <= temp_diff[16];
						tmag_q <= temp_mag;
						if (func) begin
							charger_mode_q <= charger_event;
							if (charger_event == bsc_pkg::EV_DONE) begin
								report_status_q <= bsc_pkg::STAT_FULL;
							end else if (charger_event == bsc_pkg::EV_DISCHARGING) begin
								report_status_q <= bsc_pkg::STAT_DISCHARGING;
							end
							ok_q      <= 1'b0;
							changed_q <= 1'b1;
							state_q   <= S_FIN;
						end else if (!status_ok) begin
							charge_level_q <= pct_in;
							ok_q           <= 1'b0;
							changed_q      <= 1'b0;
							state_q        <= S_FIN;
						end else if (temp_ok) begin
							state_q <= S_TEMP;
						end else begin
							state_q <= S_DECODE;
						end
					end
				end

				S_TEMP: begin
					// Readings outside -100..100 degrees leave the last value in place.
					if (!temp_over) begin
						last_temp_q <= neg_q ? -temp_pos : temp_pos;
					end
					state_q <= S_DECODE;
				end

				S_DECODE: begin
					ok_q    <= 1'b1;
					state_q <= div_go ? S_SDIV : S_FIN;
					if (st_q[bsc_pkg::FLAG_FULL]) begin
						charge_level_q  <= bsc_pkg::PCT_FULL;
						full_scale_q    <= pct_q;
						health_q        <= bsc_pkg::HEALTH_GOOD;
						level_q         <= bsc_pkg::LEVEL_FULL;
						changed_q       <= (report_status_q != bsc_pkg::STAT_FULL);
						report_status_q <= bsc_pkg::STAT_FULL;
					end else if (st_q[bsc_pkg::FLAG_EMPTY]) begin
						charge_level_q  <= '0;
						health_q        <= bsc_pkg::HEALTH_DEAD;
						level_q         <= bsc_pkg::LEVEL_CRITICAL;
						changed_q       <= (report_status_q != bsc_pkg::STAT_NOT_CHARGING);
						report_status_q <= bsc_pkg::STAT_NOT_CHARGING;
					end else if (overheat) begin
						health_q        <= bsc_pkg::HEALTH_OVERHEAT;
						changed_q       <= (report_status_q != bsc_pkg::STAT_NOT_CHARGING);
						report_status_q <= bsc_pkg::STAT_NOT_CHARGING;
					end else if (st_q[bsc_pkg::FLAG_OVERCHG]) begin
						health_q        <= bsc_pkg::HEALTH_FAILURE;
						changed_q       <= (report_status_q != bsc_pkg::STAT_NOT_CHARGING);
						report_status_q <= bsc_pkg::STAT_NOT_CHARGING;
					end else begin
						health_q <= bsc_pkg::HEALTH_GOOD;
						level_q  <= bsc_pkg::LEVEL_NORMAL;
						if ((full_scale_q != '0) && (pct_q > full_scale_q)) begin
							// Above the learned full scale the gauge reads full.
							charge_level_q  <= bsc_pkg::PCT_FULL;
							changed_q       <= (report_status_q != bsc_pkg::STAT_FULL);
							report_status_q <= bsc_pkg::STAT_FULL;
						end else if (round_num <= shift_off) begin
							// The offset swallows the whole charge.
							charge_level_q  <= '0;
							changed_q       <= (report_status_q !=
								norm_status('0, charger_mode_q, st_q[bsc_pkg::FLAG_DISCHG]));
							report_status_q <=
								norm_status('0, charger_mode_q, st_q[bsc_pkg::FLAG_DISCHG]);
						end else begin
							div_req_q.dividend <= 16'(round_num - shift_off);
							div_req_q.divisor  <= shift_den;
						end
					end
				end

				S_SDIV: begin
					if (div_rsp.done) begin
						if (full_scale_q == '0) begin
							charge_level_q  <= div_clamped;
							changed_q       <= (report_status_q != norm_status(div_clamped,
								charger_mode_q, st_q[bsc_pkg::FLAG_DISCHG]));
							report_status_q <= norm_status(div_clamped, charger_mode_q,
								st_q[bsc_pkg::FLAG_DISCHG]);
							state_q         <= S_FIN;
						end else begin
							div_req_q.dividend <= 16'(div_clamped) * 16'(bsc_pkg::PCT_FULL);
							div_req_q.divisor  <= full_scale_q;
							state_q            <= S_FDIV;
						end
					end
				end

				S_FDIV: begin
					if (div_rsp.done) begin
						charge_level_q  <= div_clamped;
						changed_q       <= (report_status_q != norm_status(div_clamped,
							charger_mode_q, st_q[bsc_pkg::FLAG_DISCHG]));
						report_status_q <= norm_status(div_clamped, charger_mode_q,
							st_q[bsc_pkg::FLAG_DISCHG]);
						state_q         <= S_FIN;
					end
				end

				S_FIN: begin
					// The result word snapshots the gauge state as this word left it.
					if (slot_free) begin
						poll_ok_q        <= ok_q;
						status_code_q    <= report_status_q;
						health_code_q    <= health_q;
						level_code_q     <= level_q;
						charge_percent_q <= charge_level_q;
						temp_c_q         <= last_temp_q;
						status_changed_q <= changed_q;
						state_q          <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign poll_ok        = poll_ok_q;
	assign status_code    = status_code_q;
	assign health_code    = health_code_q;
	assign level_code     = level_code_q;
	assign charge_percent = charge_percent_q;
	assign temp_c         = temp_c_q;
	assign status_changed = status_changed_q;

endmodule

### hw/rtl/bsc_port_checker.sv
// Port-level assertions for the battery status classifier and their bind to the top level.
module bsc_port_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               poll_ok,
	input logic [2:0]         health_code,
	input logic [6:0]         charge_percent,
	input logic signed [7:0]  temp_c,
	input logic               status_changed
);

	// A stalled result word keeps its valid, its charge and its changed flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(charge_percent) &&
		$stable(status_changed))
		else $error("result word changed while stalled");

	// Each word is worked on alone: taking one drops ready on the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while the first is in progress");

	// A decoded poll always settles the health to a known code.
	a_poll_health: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && poll_ok |-> health_code != bsc_pkg::HEALTH_UNKNOWN)
		else $error("decoded poll left health unknown");

	// Reported values stay within their ranges.
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> charge_percent <= 7'd100 && temp_c >= -8'sd100 && temp_c <= 8'sd100)
		else $error("reported charge or temperature out of range");

endmodule

bind battery_status_soc_classifier_top bsc_port_checker u_bsc_port_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.poll_ok        (poll_ok),
	.health_code    (health_code),
	.charge_percent (charge_percent),
	.temp_c         (temp_c),
	.status_changed (status_changed)
);

### tb/battery_status_soc_classifier_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the battery status and state-of-charge classifier top level.
module battery_status_soc_classifier_top_tb;
	import bsc_pkg::*;

	// Item kinds and the one charger event that the package leaves unnamed.
	localparam logic       FUNC_POLL    = 1'b0;
	localparam logic       FUNC_CHARGER = 1'b1;
	localparam logic [1:0] EV_UNKNOWN   = 2'd3;

	// Receiver behaviour: always ready, mostly ready, or mostly stalled.
	localparam int SINK_STEADY = 0;
	localparam int SINK_PATCHY = 1;
	localparam int SINK_CHOKED = 2;

	localparam int REPORT_LIMIT  = 10;
	localparam int SETTLE_CYCLES = 128;
	// The limit leaves a wide margin over the slowest legal run.
	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	typedef struct packed {
		logic        func;
		logic [6:0]  raw_charge;
		logic        charge_ok;
		logic [15:0] status_bits;
		logic        status_ok;
		logic [15:0] raw_temp;
		logic        temp_ok;
		logic [1:0]  charger_event;
	} gauge_word_t;

	typedef struct packed {
		logic       poll_ok;
		logic [2:0] status_code;
		logic [2:0] health_code;
		logic [1:0] level_code;
		logic [6:0] charge_percent;
		logic [7:0] temp_c;
		logic       status_changed;
	} gauge_report_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic        in_valid      = 1'b0;
	logic        in_ready;
	logic        func          = 1'b0;
	logic [6:0]  raw_charge    = '0;
	logic        charge_ok     = 1'b0;
	logic [15:0] status_bits   = '0;
	logic        status_ok     = 1'b0;
	logic [15:0] raw_temp      = '0;
	logic        temp_ok       = 1'b0;
	logic [1:0]  charger_event = '0;

	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              poll_ok;
	logic [2:0]        status_code;
	logic [2:0]        health_code;
	logic [1:0]        level_code;
	logic [6:0]        charge_percent;
	logic signed [7:0] temp_c;
	logic              status_changed;

	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [3:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	battery_status_soc_classifier_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.raw_charge     (raw_charge),
		.charge_ok      (charge_ok),
		.status_bits    (status_bits),
		.status_ok      (status_ok),
		.raw_temp       (raw_temp),
		.temp_ok        (temp_ok),
		.charger_event  (charger_event),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.poll_ok        (poll_ok),
		.status_code    (status_code),
		.health_code    (health_code),
		.level_code     (level_code),
		.charge_percent (charge_percent),
		.temp_c         (temp_c),
		.status_changed (status_changed),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	// Shadow copy of the registers, kept exactly as the block should hold them.
	logic [3:0]        cfg_shift      = 4'd0;
	logic              cfg_alarm_en   = 1'b0;
	logic signed [7:0] cfg_alarm_temp = 8'sd45;

	// Shadow copy of the gauge state, at its reset values.
	logic [6:0]        soc_level      = 7'd0;
	logic [6:0]        full_scale     = 7'd0;
	logic [2:0]        rep_status     = STAT_DISCHARGING;
	logic [2:0]        health         = HEALTH_UNKNOWN;
	logic [1:0]        cap_level      = LEVEL_UNKNOWN;
	logic signed [7:0] last_deg       = 8'sd0;
	logic [1:0]        chg_mode       = EV_DISCHARGING;

	gauge_report_t pending_reports[$];
	int            mismatch_count = 0;
	int            burst_left     = 0;
	int            sink_mode      = SINK_STEADY;
	int            sink_left      = 0;
	int unsigned   cycle_count    = 0;
	gauge_report_t seen_report;
	gauge_report_t want_report;
	string         diffs;

	initial begin
		forever #4 clk = ~clk;
	end

	// Removes the charge offset and stretches what is left back over the full range, adding
	// 50 to the scaled charge as a rounding term. The shift arrives already saturated.
	function automatic int offset_rescale(input int pct, input int shift);
		int num;
		num = pct * int'(PCT_FULL) + 50;
		if (num <= shift * int'(PCT_FULL))
			return 0;
		return (num - shift * int'(PCT_FULL)) / (int'(PCT_FULL) - shift);
	endfunction

	// Advances the shadow gauge state by one word and returns the report it should produce.
	function automatic gauge_report_t classify_word(input gauge_word_t w);
		gauge_report_t r;
		logic [6:0]    pct;
		logic [2:0]    next_status;
		int            deg;
		int            scaled;
		logic          changed;
		r = '0;
		if (w.func == FUNC_CHARGER) begin
			// A charger event only records the mode, and forces the status for two of them.
			chg_mode = w.charger_event;
			if (w.charger_event == EV_DONE)
				rep_status = STAT_FULL;
			else if (w.charger_event == EV_DISCHARGING)
				rep_status = STAT_DISCHARGING;
			r.poll_ok = 1'b0;
			changed = 1'b1;
		end else begin
			pct = (w.raw_charge > PCT_FULL) ? PCT_FULL : w.raw_charge;
			if (!w.charge_ok)
				pct = PCT_FALLBACK;
			if (!w.status_ok) begin
				// Without a status word only the charge is kept.
				soc_level = pct;
				r.poll_ok = 1'b0;
				changed = 1'b0;
			end else begin
				if (w.temp_ok) begin
					// Integer division truncates toward zero, as the conversion demands.
					deg = (int'(w.raw_temp) - int'(TEMP_ZERO_DK)) / 10;
					if (deg >= -100 && deg <= 100)
						last_deg = deg[7:0];
				end
				if (w.status_bits[FLAG_FULL]) begin
					next_status = STAT_FULL;
					soc_level = PCT_FULL;
					full_scale = pct;
					health = HEALTH_GOOD;
					cap_level = LEVEL_FULL;
				end else if (w.status_bits[FLAG_EMPTY]) begin
					next_status = STAT_NOT_CHARGING;
					health = HEALTH_DEAD;
					cap_level = LEVEL_CRITICAL;
					soc_level = 7'd0;
				end else if (w.status_bits[FLAG_OVERTEMP] ||
						(cfg_alarm_en && last_deg >= cfg_alarm_temp)) begin
					next_status = STAT_NOT_CHARGING;
					health = HEALTH_OVERHEAT;
				end else if (w.status_bits[FLAG_OVERCHG]) begin
					next_status = STAT_NOT_CHARGING;
					health = HEALTH_FAILURE;
				end else begin
					health = HEALTH_GOOD;
					cap_level = LEVEL_NORMAL;
					if (full_scale == 7'd0)
						scaled = offset_rescale(int'(pct), int'(cfg_shift));
					else if (pct > full_scale)
						scaled = int'(PCT_FULL);
					else
						scaled = (int'(PCT_FULL) * offset_rescale(int'(pct), int'(cfg_shift)))
							/ int'(full_scale);
					if (scaled > int'(PCT_FULL))
						scaled = int'(PCT_FULL);
					soc_level = scaled[6:0];
					if (scaled >= int'(PCT_FULL))
						next_status = STAT_FULL;
					else if (chg_mode != EV_CHARGING)
						next_status = STAT_NOT_CHARGING;
					else if (w.status_bits[FLAG_DISCHG])
						next_status = STAT_DISCHARGING;
					else
						next_status = STAT_CHARGING;
				end
				changed = (rep_status != next_status);
				rep_status = next_status;
				r.poll_ok = 1'b1;
			end
		end
		r.status_code = rep_status;
		r.health_code = health;
		r.level_code = cap_level;
		r.charge_percent = soc_level;
		r.temp_c = last_deg;
		r.status_changed = changed;
		return r;
	endfunction

	function automatic gauge_word_t make_poll(input logic [6:0] charge, input logic c_ok,
			input logic [15:0] bits, input logic s_ok, input logic [15:0] temp, input logic t_ok);
		gauge_word_t w;
		w.func = FUNC_POLL;
		w.raw_charge = charge;
		w.charge_ok = c_ok;
		w.status_bits = bits;
		w.status_ok = s_ok;
		w.raw_temp = temp;
		w.temp_ok = t_ok;
		// The event field means nothing on a poll, so it carries noise.
		w.charger_event = 2'($urandom);
		return w;
	endfunction

	function automatic gauge_word_t make_event(input logic [1:0] ev);
		gauge_word_t w;
		// Everything but the event is ignored on a charger event; fill it with noise.
		w = make_poll(7'($urandom), 1'($urandom), 16'($urandom), 1'($urandom),
			16'($urandom), 1'($urandom));
		w.func = FUNC_CHARGER;
		w.charger_event = ev;
		return w;
	endfunction

	// Mostly well-formed polls that reach the decode, with a share of failed reads,
	// out-of-range temperatures, over-range charges and charger events mixed in.
	function automatic gauge_word_t random_word();
		gauge_word_t w;
		logic [15:0] bits;
		if ($urandom_range(0, 99) < 12)
			return make_event(2'($urandom));
		bits = 16'($urandom);
		bits[FLAG_FULL]     = ($urandom_range(0, 99) < 8);
		bits[FLAG_EMPTY]    = ($urandom_range(0, 99) < 8);
		bits[FLAG_OVERTEMP] = ($urandom_range(0, 99) < 8);
		bits[FLAG_OVERCHG]  = ($urandom_range(0, 99) < 8);
		bits[FLAG_DISCHG]   = 1'($urandom_range(0, 1));
		w = make_poll(
			($urandom_range(0, 99) < 80) ? 7'($urandom_range(0, 100)) : 7'($urandom),
			($urandom_range(0, 99) < 90),
			bits,
			($urandom_range(0, 99) < 90),
			($urandom_range(0, 99) < 85) ? 16'($urandom_range(1700, 3760)) : 16'($urandom),
			($urandom_range(0, 99) < 90));
		return w;
	endfunction

	// Sends one word, idling between bursts of random length, and records its expected
	// report once the word has been taken.
	task automatic send_word(input gauge_word_t w);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		{func, raw_charge, charge_ok, status_bits, status_ok, raw_temp, temp_ok,
			charger_event} <= w;
		do @(posedge clk); while (!in_ready);
		pending_reports.push_back(classify_word(w));
	endtask

	// Stops sending and waits until every outstanding report has come back.
	task automatic wait_for_reports();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending_reports.size() != 0);
	endtask

	// One APB write: setup cycle, access cycle, then a bus idle cycle. The shadow copy is
	// updated with the same saturation and truncation the block applies.
	task automatic write_register(input logic [1:0] index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (index)
			REG_SOC_SHIFT:    cfg_shift = (value[3:0] > SHIFT_MAX) ? SHIFT_MAX : value[3:0];
			REG_ALARM_ENABLE: cfg_alarm_en = value[0];
			REG_ALARM_TEMP:   cfg_alarm_temp = value[7:0];
			default:          ;
		endcase
		@(posedge clk);
	endtask

	// Directed words at the reset settings: charge saturation and fallback, failed reads,
	// the temperature window edges and rounding toward zero, every decode priority, the
	// full-scale learning and every charger event.
	task automatic test_directed_defaults();
		send_word(make_poll(7'd127, 1'b1, 16'h0000, 1'b0, 16'd2981, 1'b1));
		send_word(make_poll(7'd0,   1'b0, 16'h0000, 1'b0, 16'd2981, 1'b1));
		send_word(make_poll(7'd0,   1'b1, 16'h0000, 1'b1, 16'd1722, 1'b1));
		send_word(make_poll(7'd100, 1'b1, 16'h0000, 1'b1, 16'd3740, 1'b1));
		send_word(make_poll(7'd127, 1'b1, 16'h0000, 1'b1, 16'd1721, 1'b1));
		send_word(make_poll(7'd60,  1'b1, 16'h0000, 1'b1, 16'd3741, 1'b1));
		send_word(make_poll(7'd60,  1'b1, 16'h0000, 1'b1, 16'd0,    1'b1));
		send_word(make_poll(7'd60,  1'b1, 16'h0000, 1'b1, 16'hFFFF, 1'b1));
		send_word(make_poll(7'd60,  1'b1, 16'h0000, 1'b1, 16'd2722, 1'b0));
		send_word(make_poll(7'd60,  1'b1, 16'h0000, 1'b1, 16'd2722, 1'b1));
		send_word(make_poll(7'd60,  1'b1, 16'h0000, 1'b1, 16'd2740, 1'b1));
		// With the charger running, the discharging flag decides between the two
		// charging states.
		send_word(make_event(EV_CHARGING));
		send_word(make_poll(7'd70, 1'b1, 16'd1 << FLAG_DISCHG, 1'b1, 16'd2981, 1'b1));
		send_word(make_poll(7'd70, 1'b1, 16'h0000, 1'b1, 16'd2981, 1'b1));
		send_word(make_poll(7'd70, 1'b1, 16'd1 << FLAG_OVERTEMP, 1'b1, 16'd2981, 1'b1));
		send_word(make_poll(7'd70, 1'b1, 16'd1 << FLAG_OVERCHG, 1'b1, 16'd2981, 1'b1));
		send_word(make_poll(7'd10, 1'b1, 16'd1 << FLAG_EMPTY, 1'b1, 16'd2981, 1'b1));
		// Learn a full scale of 80, then rescale above and below it.
		send_word(make_poll(7'd80, 1'b1, 16'd1 << FLAG_FULL, 1'b1, 16'd2981, 1'b1));
		send_word(make_poll(7'd90, 1'b1, 16'h0000, 1'b1, 16'd2981, 1'b1));
		send_word(make_poll(7'd40, 1'b1, 16'h0000, 1'b1, 16'd2981, 1'b1));
		send_word(make_poll(7'd55, 1'b1, 16'hFFFF, 1'b1, 16'd2981, 1'b1));
		send_word(make_event(EV_DONE));
		send_word(make_event(EV_UNKNOWN));
		send_word(make_event(EV_DISCHARGING));
		wait_for_reports();
	endtask

	// Offset shift at and beyond its limit, the shift exceeding the charge, and the
	// measured-temperature alarm at both ends of its range.
	task automatic test_shift_and_alarm();
		write_register(REG_SOC_SHIFT, 32'd15);
		write_register(REG_ALARM_ENABLE, 32'd1);
		write_register(REG_ALARM_TEMP, 32'(8'(-100)));
		// Clear the learned full scale so that the plain offset rescaling is used.
		send_word(make_poll(7'd0, 1'b1, 16'd1 << FLAG_FULL, 1'b1, 16'd1722, 1'b1));
		send_word(make_poll(7'd5, 1'b1, 16'h0000, 1'b1, 16'd1722, 1'b1));
		wait_for_reports();
		write_register(REG_ALARM_TEMP, 32'd100);
		send_word(make_poll(7'd5,   1'b1, 16'h0000, 1'b1, 16'd3740, 1'b1));
		send_word(make_poll(7'd5,   1'b1, 16'h0000, 1'b1, 16'd3730, 1'b1));
		send_word(make_poll(7'd100, 1'b1, 16'h0000, 1'b1, 16'd3730, 1'b1));
		send_word(make_poll(7'd11,  1'b1, 16'h0000, 1'b1, 16'd3730, 1'b1));
		send_word(make_poll(7'd0,   1'b0, 16'h0000, 1'b1, 16'd3730, 1'b1));
		wait_for_reports();
		write_register(REG_SOC_SHIFT, 32'd10);
		write_register(REG_ALARM_TEMP, 32'h0000_007F);
		send_word(make_poll(7'd100, 1'b1, 16'h0000, 1'b1, 16'd3740, 1'b1));
		send_word(make_poll(7'd10,  1'b1, 16'h0000, 1'b1, 16'd3740, 1'b1));
		wait_for_reports();
		write_register(REG_ALARM_TEMP, 32'h0000_0080);
		write_register(REG_SOC_SHIFT, 32'd0);
		send_word(make_poll(7'd37, 1'b1, 16'h0000, 1'b1, 16'd1722, 1'b1));
		wait_for_reports();
		write_register(REG_ALARM_ENABLE, 32'd0);
	endtask

	// Random traffic in several phases, each under a fresh random setting of every register.
	task automatic test_random_traffic();
		for (int phase = 0; phase < 5; phase++) begin
			write_register(REG_SOC_SHIFT, 32'($urandom_range(0, 15)));
			write_register(REG_ALARM_ENABLE, 32'($urandom_range(0, 1)));
			if ($urandom_range(0, 3) != 0)
				write_register(REG_ALARM_TEMP, 32'(8'($urandom_range(0, 200) - 100)));
			else
				write_register(REG_ALARM_TEMP, 32'(8'($urandom)));
			for (int n = 0; n < 200; n++)
				send_word(random_word());
			wait_for_reports();
		end
	endtask

	// The receiver switches between steady, patchy and choked behaviour every so often,
	// so that result words are taken under each of these behaviours.
	always @(posedge clk) begin
		if (sink_left == 0) begin
			sink_mode = $urandom_range(SINK_STEADY, SINK_CHOKED);
			sink_left = $urandom_range(32, 256);
		end
		sink_left--;
		case (sink_mode)
			SINK_STEADY: out_ready <= 1'b1;
			SINK_PATCHY: out_ready <= ($urandom_range(0, 3) != 0);
			default:     out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Every report word taken from the block is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_report = {poll_ok, status_code, health_code, level_code, charge_percent,
				temp_c, status_changed};
			if (pending_reports.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("[%0t] report word %h arrived with nothing outstanding",
						$realtime, seen_report);
			end else begin
				want_report = pending_reports.pop_front();
				diffs = "";
				if (seen_report.poll_ok !== want_report.poll_ok)
					diffs = {diffs, " poll_ok"};
				if (seen_report.status_code !== want_report.status_code)
					diffs = {diffs, " status_code"};
				if (seen_report.health_code !== want_report.health_code)
					diffs = {diffs, " health_code"};
				if (seen_report.level_code !== want_report.level_code)
					diffs = {diffs, " level_code"};
				if (seen_report.charge_percent !== want_report.charge_percent)
					diffs = {diffs, " charge_percent"};
				if (seen_report.temp_c !== want_report.temp_c)
					diffs = {diffs, " temp_c"};
				if (seen_report.status_changed !== want_report.status_changed)
					diffs = {diffs, " status_changed"};
				if (diffs != "") begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("[%0t] report mismatch in%s", $realtime, diffs);
						$display("  expected ok=%0d stat=%0d health=%0d level=%0d pct=%0d temp=%0d chg=%0d",
							want_report.poll_ok, want_report.status_code,
							want_report.health_code, want_report.level_code,
							want_report.charge_percent, $signed(want_report.temp_c),
							want_report.status_changed);
						$display("  actual   ok=%0d stat=%0d health=%0d level=%0d pct=%0d temp=%0d chg=%0d",
							seen_report.poll_ok, seen_report.status_code,
							seen_report.health_code, seen_report.level_code,
							seen_report.charge_percent, $signed(seen_report.temp_c),
							seen_report.status_changed);
					end
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_defaults();
		test_shift_and_alarm();
		test_random_traffic();
		wait_for_reports();
		// Give any stray report word time to show itself before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_reports.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
